/* rtl/pept_pkg.sv */
// Shared types, codes and constants of the pattern encoder position tracker.
package pept_pkg;

	localparam int unsigned PATTERN_DEPTH_DEF = 1024;
	localparam int unsigned STAT_WIDTH_DEF = 32;

	localparam int unsigned OP_W = 3;
	localparam int unsigned POS_OUT_W = 10;
	localparam int unsigned RUN_W = 16;
	localparam int unsigned STAT_OUT_W = 32;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned MAXF_W = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [RUN_W-1:0] RUN_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
	localparam logic [MAXF_W-1:0] MAXF_RESET = 8'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LENGTH = 1'b0,
		CFG_MAX_FAILURES = 1'b1
	} cfg_reg_t;

	typedef enum logic [OP_W-1:0] {
		OP_TRACK = 3'd0,
		OP_INIT = 3'd1,
		OP_RESET = 3'd2,
		OP_LOAD = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_UNCERTAIN = 2'd1,
		ST_INVALID = 2'd2,
		ST_DONE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		MODE_UNINIT = 3'b001,
		MODE_TRACKING = 3'b010,
		MODE_LOST = 3'b100
	} mode_t;

	localparam logic [1:0] MODE_CODE_UNINIT = 2'd0;
	localparam logic [1:0] MODE_CODE_TRACKING = 2'd1;
	localparam logic [1:0] MODE_CODE_LOST = 2'd2;

	typedef struct packed {
		op_t op;
		logic sensed_bit;
	} item_ctl_t;

	typedef struct packed {
		status_t status;
		logic [POS_OUT_W-1:0] track_pos;
		logic [1:0] tracker_mode;
		logic [RUN_W-1:0] failure_count;
		logic [STAT_OUT_W-1:0] update_count;
		logic [STAT_OUT_W-1:0] hit_count;
		logic [STAT_OUT_W-1:0] miss_count;
		logic [STAT_OUT_W-1:0] correction_count;
	} result_t;

	// Position registers are at least as wide as the start index field.
	function automatic int unsigned pos_width(int unsigned depth);
		int unsigned aw;
		aw = (depth > 1) ? $clog2(depth) : 1;
		return (aw > POS_OUT_W) ? aw : POS_OUT_W;
	endfunction

	function automatic int unsigned addr_width(int unsigned depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic logic [1:0] mode_code(mode_t m);
		logic [1:0] c;
		case (m)
			MODE_UNINIT: c = MODE_CODE_UNINIT;
			MODE_TRACKING: c = MODE_CODE_TRACKING;
			MODE_LOST: c = MODE_CODE_LOST;
			default: c = MODE_CODE_UNINIT;
		endcase
		return c;
	endfunction

endpackage

/* rtl/pept_in_if.sv */
// Input channel interface: one track item per transaction.
interface pept_in_if;
	logic valid;
	logic ready;
	logic [2:0] operation;
	logic sensed_bit;
	logic move_backward;
	logic [9:0] position_index;

	modport source (output valid, operation, sensed_bit, move_backward, position_index,
		input ready);
	modport sink (input valid, operation, sensed_bit, move_backward, position_index,
		output ready);
endinterface

/* rtl/pept_out_if.sv */
// Output channel interface: one tracker result per transaction.
interface pept_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [9:0] track_pos;
	logic [1:0] tracker_mode;
	logic [15:0] failure_count;
	logic [31:0] update_count;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] correction_count;

	modport source (output valid, status, track_pos, tracker_mode, failure_count,
		update_count, hit_count, miss_count, correction_count,
		input ready);
	modport sink (input valid, status, track_pos, tracker_mode, failure_count,
		update_count, hit_count, miss_count, correction_count,
		output ready);
endinterface

/* rtl/pattern_encoder_position_tracker_top.sv */
// Top level of the pattern encoder position tracker.
//
//   Channel   Direction  Payload                                          Handshake
//   item      in         operation, sensed_bit, move_backward,            valid/ready
//                        position_index
//   result    out        status, track_pos, tracker_mode,                 valid/ready
//                        failure_count and the four statistics counters
//   cfg       in         cfg_index, cfg_data                               cfg_we only
//
// A transaction is accepted into stage one, and its result is then registered in the
// result register, from which it is offered; a new transaction is accepted in every
// cycle while the output does not stall.
// The acceptance edge reads the code track store at the stepped and the unchanged
// position; stage one compares and updates the tracker, and the result register
// holds the outcome.
// The step addresses of an accepted transaction are formed from the position that
// the transaction in stage one leaves, so no bubble separates dependent items.
// Reset clears the tracker state, the statistics and the valid flags at once; the
// track store has no clearing pass and holds unknown bits until they are loaded.
// A stalled result holds its register; stage one can still take one more
// transaction, and once it is full the input stalls as well.
module pattern_encoder_position_tracker_top import pept_pkg::*; #(
	parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int unsigned STAT_WIDTH = STAT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	pept_in_if.sink item,
	pept_out_if.source result
);

	localparam int unsigned PW = pos_width(PATTERN_DEPTH);
	localparam int unsigned AW = addr_width(PATTERN_DEPTH);
	localparam logic [PW:0] DEPTH_V = (PW+1)'(PATTERN_DEPTH);

	logic [PW:0] len_eff;
	logic [MAXF_W-1:0] max_failures;

	logic accept;
	logic adv_s1;
	op_t in_op;

	// Address generation for the item being accepted.
	logic [PW-1:0] pos_fwd;
	logic [PW:0] pos_inc;
	logic [PW-1:0] step_fwd, step_bwd, step_pos, idx_ext;
	logic step_ok, cur_ok, idx_ok;

	// Stage one.
	logic valid_s1;
	item_ctl_t ctl_s1;
	logic [PW-1:0] pos_arg_s1;
	logic next_ok_s1, cur_ok_s1;
	logic rd_next, rd_cur;

	// Result register.
	logic valid_s2;
	result_t res_s2;
	result_t res;

	pept_cfg_regs #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.len_eff(len_eff),
		.max_failures(max_failures)
	);

	// Stage one moves on whenever the result register is empty or being taken.
	assign adv_s1 = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || adv_s1;
	assign accept = item.valid && item.ready;
	assign in_op = op_t'(item.operation);

	// One step along the track, wrapping at the effective length. A position at or
	// past the length also wraps to zero when stepping forward.
	assign pos_inc = {1'b0, pos_fwd} + 1'b1;
	assign step_fwd = (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];
	assign step_bwd = (pos_fwd == '0) ? PW'(len_eff - 1'b1) : pos_fwd - 1'b1;
	assign step_pos = item.move_backward ? step_bwd : step_fwd;

	// Places outside the store read as a zero code bit.
	assign step_ok = {1'b0, step_pos} < DEPTH_V;
	assign cur_ok = {1'b0, pos_fwd} < DEPTH_V;
	assign idx_ext = PW'(item.position_index);
	assign idx_ok = {1'b0, idx_ext} < DEPTH_V;

	pept_pattern_mem #(.PATTERN_DEPTH(PATTERN_DEPTH)) u_mem (
		.clk(clk),
		.we(accept && (in_op == OP_LOAD) && idx_ok),
		.waddr(idx_ext[AW-1:0]),
		.wdata(item.sensed_bit),
		.re(accept),
		.raddr_a(step_pos[AW-1:0]),
		.raddr_b(pos_fwd[AW-1:0]),
		.rdata_a(rd_next),
		.rdata_b(rd_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.op <= in_op;
			ctl_s1.sensed_bit <= item.sensed_bit;
			pos_arg_s1 <= (in_op == OP_INIT) ? idx_ext : step_pos;
			next_ok_s1 <= step_ok;
			cur_ok_s1 <= cur_ok;
		end
	end

	pept_track_unit #(
		.PATTERN_DEPTH(PATTERN_DEPTH),
		.STAT_WIDTH(STAT_WIDTH)
	) u_track (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(valid_s1),
		.advance(adv_s1),
		.ctl(ctl_s1),
		.pos_arg(pos_arg_s1),
		.bit_next(next_ok_s1 & rd_next),
		.bit_cur(cur_ok_s1 & rd_cur),
		.max_failures(max_failures),
		.pos_fwd(pos_fwd),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign result.valid = valid_s2;
	assign result.status = res_s2.status;
	assign result.track_pos = res_s2.track_pos;
	assign result.tracker_mode = res_s2.tracker_mode;
	assign result.failure_count = res_s2.failure_count;
	assign result.update_count = res_s2.update_count;
	assign result.hit_count = res_s2.hit_count;
	assign result.miss_count = res_s2.miss_count;
	assign result.correction_count = res_s2.correction_count;

endmodule

/* rtl/pept_cfg_regs.sv */
// Configuration registers and the clamped effective track length.
module pept_cfg_regs import pept_pkg::*; #(
	parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	localparam int unsigned PW = pos_width(PATTERN_DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output logic [PW:0] len_eff,
	output logic [MAXF_W-1:0] max_failures
);

	localparam logic [PW:0] DEPTH_V = (PW+1)'(PATTERN_DEPTH);

	logic [LEN_W-1:0] length_q;
	logic [MAXF_W-1:0] maxf_q;
	logic [PW:0] len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_RESET;
			maxf_q <= MAXF_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				CFG_MAX_FAILURES: maxf_q <= cfg_data[MAXF_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero length acts as one; a length past the store acts as the store depth.
	assign len_ext = (PW+1)'(length_q);
	always_comb begin
		if (length_q == '0) begin
			len_eff = (PW+1)'(1);
		end else if (len_ext > DEPTH_V) begin
			len_eff = DEPTH_V;
		end else begin
			len_eff = len_ext;
		end
	end

	assign max_failures = maxf_q;

endmodule

/* rtl/pept_pattern_mem.sv */
// Code track store: one write port and two registered read ports.
module pept_pattern_mem import pept_pkg::*; #(
	parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	localparam int unsigned AW = addr_width(PATTERN_DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic wdata,
	input logic re,
	input logic [AW-1:0] raddr_a,
	input logic [AW-1:0] raddr_b,
	output logic rdata_a,
	output logic rdata_b
);

	logic mem [PATTERN_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* rtl/pept_track_unit.sv */
// Tracker state, statistics and the per-item update of stage one.
module pept_track_unit import pept_pkg::*; #(
	parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF,
	parameter int unsigned STAT_WIDTH = STAT_WIDTH_DEF,
	localparam int unsigned PW = pos_width(PATTERN_DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic advance,
	input item_ctl_t ctl,
	input logic [PW-1:0] pos_arg,
	input logic bit_next,
	input logic bit_cur,
	input logic [MAXF_W-1:0] max_failures,
	output logic [PW-1:0] pos_fwd,
	output result_t res
);

	logic [PW-1:0] pos_q, pos_n;
	mode_t mode_q, mode_n;
	logic [RUN_W-1:0] run_q, run_n, run_inc;
	logic [STAT_WIDTH-1:0] upd_q, upd_n, ok_q, ok_n, fail_q, fail_n, corr_q, corr_n;
	status_t status;

	assign run_inc = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;

	always_comb begin
		pos_n = pos_q;
		mode_n = mode_q;
		run_n = run_q;
		upd_n = upd_q;
		ok_n = ok_q;
		fail_n = fail_q;
		corr_n = corr_q;
		status = ST_INVALID;
		case (ctl.op)
			OP_TRACK: begin
				if (mode_q != MODE_UNINIT) begin
					upd_n = upd_q + 1'b1;
					if (bit_next == ctl.sensed_bit) begin
						pos_n = pos_arg;
						run_n = '0;
						ok_n = ok_q + 1'b1;
						mode_n = MODE_TRACKING;
						status = ST_VALID;
					end else begin
						run_n = run_inc;
						fail_n = fail_q + 1'b1;
						if (run_inc >= RUN_W'(max_failures)) begin
							// Threshold reached: the bit at the old place may still vouch.
							if (bit_cur == ctl.sensed_bit) begin
								run_n = '0;
								mode_n = MODE_TRACKING;
								corr_n = corr_q + 1'b1;
								status = ST_VALID;
							end else begin
								mode_n = MODE_LOST;
								status = ST_INVALID;
							end
						end else begin
							status = ST_UNCERTAIN;
						end
					end
				end
			end
			OP_INIT: begin
				pos_n = pos_arg;
				mode_n = MODE_TRACKING;
				run_n = '0;
				status = ST_DONE;
			end
			OP_RESET: begin
				pos_n = '0;
				mode_n = MODE_UNINIT;
				run_n = '0;
				status = ST_DONE;
			end
			OP_LOAD: begin
				status = ST_DONE;
			end
			OP_CLEAR: begin
				upd_n = '0;
				ok_n = '0;
				fail_n = '0;
				corr_n = '0;
				status = ST_DONE;
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			mode_q <= MODE_UNINIT;
			run_q <= '0;
			upd_q <= '0;
			ok_q <= '0;
			fail_q <= '0;
			corr_q <= '0;
		end else if (item_valid && advance) begin
			pos_q <= pos_n;
			mode_q <= mode_n;
			run_q <= run_n;
			upd_q <= upd_n;
			ok_q <= ok_n;
			fail_q <= fail_n;
			corr_q <= corr_n;
		end
	end

	// The next item's addresses are formed from the position this item leaves.
	assign pos_fwd = item_valid ? pos_n : pos_q;

	always_comb begin
		res.status = status;
		res.track_pos = POS_OUT_W'(pos_n);
		res.tracker_mode = mode_code(mode_n);
		res.failure_count = run_n;
		res.update_count = STAT_OUT_W'(upd_n);
		res.hit_count = STAT_OUT_W'(ok_n);
		res.miss_count = STAT_OUT_W'(fail_n);
		res.correction_count = STAT_OUT_W'(corr_n);
	end

endmodule

/* rtl/pept_checker.sv */
// Port-level checks on the tracker results, bound to the top level.
module pept_checker import pept_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [9:0] track_pos,
	input logic [1:0] tracker_mode,
	input logic [15:0] failure_count
);

	// A result that is not taken stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A valid status comes only from a match or a correction, both of which end the run.
	a_valid_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_VALID) |-> (failure_count == '0) &&
		(tracker_mode == MODE_CODE_TRACKING))
		else $error("valid status with a mismatch run or not tracking");

	// Before initialization the tracker sits at the origin with no run.
	a_uninit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tracker_mode == MODE_CODE_UNINIT) |->
		(track_pos == '0) && (failure_count == '0))
		else $error("uninitialized tracker has moved or counts failures");

	// Being lost always follows at least one mismatch.
	a_lost_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tracker_mode == MODE_CODE_LOST) |-> (failure_count != '0))
		else $error("lost tracker with an empty mismatch run");

endmodule

bind pattern_encoder_position_tracker_top pept_checker u_pept_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.status(result.status),
	.track_pos(result.track_pos),
	.tracker_mode(result.tracker_mode),
	.failure_count(result.failure_count)
);
